>>> hw/rtl/mwrl_pkg.sv
// mwrl_pkg: shared types and constants of the multi-window rate limiter
// used by mwrl_alu and multi_window_client_rate_limiter; depends on nothing
package mwrl_pkg;

  localparam logic [31:0] MINUTE_LEN = 32'd60;
  localparam logic [31:0] HOUR_LEN   = 32'd3600;
  localparam logic [31:0] DAY_LEN    = 32'd86400;
  localparam logic [15:0] UNLIMITED_REMAINING = 16'd999;

  localparam logic [1:0] WIN_MINUTE = 2'd0;
  localparam logic [1:0] WIN_HOUR   = 2'd1;
  localparam logic [1:0] WIN_DAY    = 2'd2;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] diff;
    logic        borrow;
  } alu_res_t;

  function automatic logic [31:0] win_len(input logic [1:0] w);
    logic [31:0] len;
    case (w)
      WIN_MINUTE: len = MINUTE_LEN;
      WIN_HOUR:   len = HOUR_LEN;
      default:    len = DAY_LEN;
    endcase
    return len;
  endfunction

endpackage

>>> hw/rtl/mwrl_alu.sv
// mwrl_alu: shared 32-bit subtractor with borrow out, used for ages,
// window expiry, reset times, limit checks and the remaining count; uses mwrl_pkg
module mwrl_alu (
  input  mwrl_pkg::alu_req_t req,
  output mwrl_pkg::alu_res_t res
);
  import mwrl_pkg::*;

  logic [32:0] diff_w;

  assign diff_w     = {1'b0, req.a} - {1'b0, req.b};
  assign res.diff   = diff_w[31:0];
  assign res.borrow = diff_w[32];

endmodule

>>> hw/rtl/mwrl_table.sv
// mwrl_table: per-client entry memory, one write port and one registered read port
// entries hold valid, three window starts and three counts; no dependencies
module mwrl_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 145
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem_r [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/multi_window_client_rate_limiter.sv
// multi_window_client_rate_limiter: top level, sequencer and entry datapath
// uses mwrl_pkg, mwrl_alu (shared subtractor) and mwrl_table (entry memory)
//
//   channel | direction | ports
//   --------+-----------+---------------------------------------------------------
//   in      | input     | in_valid, in_stall, in_client_index, in_now_seconds,
//           |           | in_minute_limit, in_hour_limit, in_day_limit
//   out     | output    | out_valid, out_stall, out_allowed, out_limit_applied,
//           |           | out_remaining, out_reset_after, out_window_code
//
// one item at a time; its steps are those of the single shared subtractor (three
// steps per window, one to three limit checks, one for remaining when allowed) plus
// slot, table read, write-back and output steps, plus a slot reduction step that
// repeats while client_index >= CLIENT_SLOTS
// after reset a clearing pass writes every entry, with in_stall high
// the result waits in an output register; a stalled out channel only delays the
// finish of the next item, which is already taken in
module multi_window_client_rate_limiter #(
  parameter int CLIENT_SLOTS = 256,
  parameter int COUNT_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_client_index,
  input  logic [31:0] in_now_seconds,
  input  logic [15:0] in_minute_limit,
  input  logic [15:0] in_hour_limit,
  input  logic [15:0] in_day_limit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_allowed,
  output logic [15:0] out_limit_applied,
  output logic [15:0] out_remaining,
  output logic [16:0] out_reset_after,
  output logic [1:0]  out_window_code
);
  import mwrl_pkg::*;

  localparam int AW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
  localparam int CB = COUNT_BITS;
  localparam int DW = 1 + 3 * 32 + 3 * CB;

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_MOD  = 4'd2;
  localparam logic [3:0] S_LOAD = 4'd3;
  localparam logic [3:0] S_AGE  = 4'd4;
  localparam logic [3:0] S_EXP  = 4'd5;
  localparam logic [3:0] S_RST  = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_REM  = 4'd8;
  localparam logic [3:0] S_WB   = 4'd9;
  localparam logic [3:0] S_OUT  = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_load;

  logic [7:0]    idx_r;
  logic [31:0]   now_r;
  logic [15:0]   lim_r   [3];
  logic [31:0]   start_r [3];
  logic [CB-1:0] cnt_r   [3];
  logic [16:0]   rst_r   [3];
  logic [31:0]   age_r;
  logic [1:0]    win_r;

  logic          res_allowed_r;
  logic [15:0]   res_limit_r;
  logic [15:0]   res_remaining_r;
  logic [16:0]   res_reset_after_r;
  logic [1:0]    res_code_r;

  logic          out_allowed_r;
  logic [15:0]   out_limit_applied_r;
  logic [15:0]   out_remaining_r;
  logic [16:0]   out_reset_after_r;
  logic [1:0]    out_window_code_r;

  alu_req_t      alu_req;
  alu_res_t      alu_res;

  logic          tbl_we;
  logic [AW-1:0] tbl_waddr;
  logic [DW-1:0] tbl_wdata;
  logic [DW-1:0] tbl_rdata;
  logic [AW-1:0] slot;

  logic          in_accept;
  logic          idx_over;
  logic          lim_hit;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot      = AW'(idx_r);
  assign idx_over  = ({24'd0, idx_r} >= 32'(CLIENT_SLOTS));
  assign lim_hit   = (lim_r[win_r] != 16'd0) && !alu_res.borrow;

  // shared subtractor operand select
  always_comb begin
    alu_req.a = now_r;
    alu_req.b = start_r[win_r];
    case (state_r)
      S_AGE: begin
        alu_req.a = now_r;
        alu_req.b = start_r[win_r];
      end
      S_EXP: begin
        alu_req.a = age_r;
        alu_req.b = win_len(win_r);
      end
      S_RST: begin
        alu_req.a = win_len(win_r);
        alu_req.b = age_r;
      end
      S_CHK: begin
        alu_req.a = 32'(cnt_r[win_r]);
        alu_req.b = 32'(lim_r[win_r]);
      end
      S_REM: begin
        alu_req.a = 32'(lim_r[WIN_MINUTE]);
        alu_req.b = 32'(cnt_r[WIN_MINUTE]);
      end
      default: begin
        alu_req.a = now_r;
        alu_req.b = start_r[win_r];
      end
    endcase
  end

  mwrl_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign tbl_we    = (state_r == S_CLR) || (state_r == S_WB);
  assign tbl_waddr = (state_r == S_CLR) ? clr_cnt_r : slot;
  assign tbl_wdata = (state_r == S_CLR) ? '0 :
                     {1'b1, start_r[2], start_r[1], start_r[0], cnt_r[2], cnt_r[1], cnt_r[0]};

  mwrl_table #(
    .DEPTH (CLIENT_SLOTS),
    .AW    (AW),
    .DW    (DW)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (slot),
    .rd_data (tbl_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(CLIENT_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        if (!idx_over) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: state_nxt = S_AGE;
      S_AGE:  state_nxt = S_EXP;
      S_EXP:  state_nxt = S_RST;
      S_RST: begin
        state_nxt = (win_r == WIN_DAY) ? S_CHK : S_AGE;
      end
      S_CHK: begin
        if (lim_hit) begin
          state_nxt = S_WB;
        end else if (win_r == WIN_DAY) begin
          state_nxt = S_REM;
        end
      end
      S_REM: state_nxt = S_WB;
      S_WB:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // entry datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          idx_r    <= in_client_index;
          now_r    <= in_now_seconds;
          lim_r[0] <= in_minute_limit;
          lim_r[1] <= in_hour_limit;
          lim_r[2] <= in_day_limit;
        end
      end
      S_MOD: begin
        if (idx_over) begin
          idx_r <= idx_r - 8'(CLIENT_SLOTS);
        end
      end
      S_LOAD: begin
        win_r <= WIN_MINUTE;
        for (int k = 0; k < 3; k++) begin
          if (tbl_rdata[DW-1]) begin
            start_r[k] <= tbl_rdata[3*CB + 32*k +: 32];
            cnt_r[k]   <= tbl_rdata[CB*k +: CB];
          end else begin
            start_r[k] <= now_r;
            cnt_r[k]   <= '0;
          end
        end
      end
      S_AGE: begin
        age_r <= alu_res.diff;
      end
      S_EXP: begin
        if (!alu_res.borrow) begin
          start_r[win_r] <= now_r;
          cnt_r[win_r]   <= '0;
          age_r          <= '0;
        end
      end
      S_RST: begin
        rst_r[win_r] <= alu_res.diff[16:0];
        win_r        <= (win_r == WIN_DAY) ? WIN_MINUTE : win_r + 2'd1;
      end
      S_CHK: begin
        if (lim_hit) begin
          res_allowed_r     <= 1'b0;
          res_limit_r       <= lim_r[win_r];
          res_remaining_r   <= 16'd0;
          res_reset_after_r <= rst_r[win_r];
          res_code_r        <= win_r;
        end else if (win_r == WIN_DAY) begin
          for (int k = 0; k < 3; k++) begin
            if (cnt_r[k] != {CB{1'b1}}) begin
              cnt_r[k] <= cnt_r[k] + CB'(1);
            end
          end
        end else begin
          win_r <= win_r + 2'd1;
        end
      end
      S_REM: begin
        res_allowed_r     <= 1'b1;
        res_limit_r       <= lim_r[WIN_MINUTE];
        res_reset_after_r <= rst_r[WIN_MINUTE];
        res_code_r        <= WIN_MINUTE;
        if (lim_r[WIN_MINUTE] == 16'd0) begin
          res_remaining_r <= UNLIMITED_REMAINING;
        end else if (alu_res.borrow) begin
          res_remaining_r <= 16'd0;
        end else begin
          res_remaining_r <= alu_res.diff[15:0];
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_allowed_r       <= res_allowed_r;
      out_limit_applied_r <= res_limit_r;
      out_remaining_r     <= res_remaining_r;
      out_reset_after_r   <= res_reset_after_r;
      out_window_code_r   <= res_code_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_allowed       = out_allowed_r;
  assign out_limit_applied = out_limit_applied_r;
  assign out_remaining     = out_remaining_r;
  assign out_reset_after   = out_reset_after_r;
  assign out_window_code   = out_window_code_r;

  a_result_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_OUT)
    else $error("result raised outside the output state");

  a_denied_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_allowed) |-> (out_remaining == 16'd0) && (out_limit_applied != 16'd0))
    else $error("denied item with remaining count or zero limit");

  a_allowed_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_allowed) |->
      (out_window_code == WIN_MINUTE) && (out_reset_after != 17'd0) &&
      (out_reset_after <= 17'd60))
    else $error("allowed item with bad window or reset time");

  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid)
    else $error("result present during clearing pass");

endmodule
